// ===== hdl/rfd_pkg.sv =====
// Package for the radar frame deframer: frame size, header and tail bytes, shared types.
// Depends on nothing; rfd_parser, rfd_reader, the top level and the testbench use it.
`default_nettype none

package rfd_pkg;

    localparam int FRAME_BYTES = 30;
    localparam int POS_W       = 6;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);

    localparam logic [7:0] HDR0  = 8'hAA;
    localparam logic [7:0] HDR1  = 8'hFF;
    localparam logic [7:0] HDR2  = 8'h03;
    localparam logic [7:0] HDR3  = 8'h00;
    localparam logic [7:0] TAIL0 = 8'h55;
    localparam logic [7:0] TAIL1 = 8'hCC;

    localparam logic [POS_W-1:0] POS_HDR1  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_HDR2  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_HDR3  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_BODY  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_TAIL0 = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_req_t;

    typedef enum logic {
        RD_IDLE,
        RD_RUN
    } rd_state_t;

endpackage

`default_nettype wire

// ===== hdl/rfd_in_if.sv =====
// Input channel of the radar frame deframer: one received byte per transaction.
// Depends on nothing.
`default_nettype none

interface rfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       call_active;
    logic       link_up;

    modport source (output valid, output data_byte, output call_active, output link_up,
                    input ready);
    modport sink   (input valid, input data_byte, input call_active, input link_up,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/rfd_out_if.sv =====
// Output channel of the radar frame deframer: one frame byte per transaction.
// Depends on nothing.
`default_nettype none

interface rfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [5:0] byte_position;
    logic       last;

    modport source (output valid, output frame_byte, output byte_position, output last,
                    input ready);
    modport sink   (input valid, input frame_byte, input byte_position, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/rfd_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module rfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rfd_parser.sv =====
// Header hunt, frame gathering and tail check of the radar frame deframer.
// Depends on rfd_pkg; drives the write port of the frame store and starts the readout.
`default_nettype none

module rfd_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      data_byte,
    input  wire logic            call_active,
    input  wire logic            link_up,
    output rfd_pkg::wr_req_t     wr_req,
    output logic                 start
);

    logic [rfd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      tail0_reg, tail0_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            tail0_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            tail0_reg <= tail0_next;
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        tail0_next   = tail0_reg;
        wr_req.en    = 1'b0;
        wr_req.addr  = pos_reg[rfd_pkg::ADDR_W-1:0];
        wr_req.data  = data_byte;
        start        = 1'b0;
        if (accept)
        begin
            if (call_active)
            begin
                pos_next = '0;
            end
            else
            begin
                case (pos_reg)
                    '0:
                    begin
                        if (data_byte == rfd_pkg::HDR0)
                        begin
                            wr_req.en = 1'b1;
                            pos_next  = rfd_pkg::POS_HDR1;
                        end
                    end
                    rfd_pkg::POS_HDR1:
                    begin
                        if (data_byte == rfd_pkg::HDR1)
                        begin
                            wr_req.en = 1'b1;
                            pos_next  = rfd_pkg::POS_HDR2;
                        end
                        else if (data_byte == rfd_pkg::HDR0)
                        begin
                            pos_next = rfd_pkg::POS_HDR1;
                        end
                        else
                        begin
                            pos_next = '0;
                        end
                    end
                    rfd_pkg::POS_HDR2:
                    begin
                        if (data_byte == rfd_pkg::HDR2)
                        begin
                            wr_req.en = 1'b1;
                            pos_next  = rfd_pkg::POS_HDR3;
                        end
                        else
                        begin
                            pos_next = '0;
                        end
                    end
                    rfd_pkg::POS_HDR3:
                    begin
                        if (data_byte == rfd_pkg::HDR3)
                        begin
                            wr_req.en = 1'b1;
                            pos_next  = rfd_pkg::POS_BODY;
                        end
                        else
                        begin
                            pos_next = '0;
                        end
                    end
                    default:
                    begin
                        if (pos_reg > rfd_pkg::POS_LAST)
                        begin
                            pos_next = '0;
                        end
                        else
                        begin
                            wr_req.en = 1'b1;
                            if (pos_reg == rfd_pkg::POS_TAIL0)
                            begin
                                tail0_next = (data_byte == rfd_pkg::TAIL0);
                            end
                            if (pos_reg == rfd_pkg::POS_LAST)
                            begin
                                pos_next = '0;
                                start    = tail0_reg && (data_byte == rfd_pkg::TAIL1)
                                           && link_up;
                            end
                            else
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rfd_reader.sv =====
// Readout of a validated frame from the frame store into the output register.
// Depends on rfd_pkg; drives the read port of the frame store and the output channel.
`default_nettype none

module rfd_reader (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    output logic                            rd_en,
    output logic [rfd_pkg::ADDR_W-1:0]      rd_addr,
    input  wire logic [7:0]                 rd_data,
    rfd_out_if.source                       out_ch
);

    rfd_pkg::rd_state_t        state_reg, state_next;
    logic [rfd_pkg::POS_W-1:0] cnt_reg, cnt_next;
    logic                      pend_reg, pend_next;
    logic [rfd_pkg::POS_W-1:0] pend_pos_reg, pend_pos_next;
    logic                      out_valid_reg, out_valid_next;
    logic [7:0]                out_byte_reg, out_byte_next;
    logic [rfd_pkg::POS_W-1:0] out_pos_reg, out_pos_next;
    logic                      out_last_reg, out_last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfd_pkg::RD_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_pos_reg <= pend_pos_next;
        out_byte_reg <= out_byte_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_pos_next  = pend_pos_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_byte_next  = out_byte_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[rfd_pkg::ADDR_W-1:0];
        busy           = (state_reg == rfd_pkg::RD_RUN);

        if (pend_reg)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = rd_data;
            out_pos_next   = pend_pos_reg;
            out_last_next  = (pend_pos_reg == rfd_pkg::POS_LAST);
        end

        case (state_reg)
            rfd_pkg::RD_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = '0;
                    state_next = rfd_pkg::RD_RUN;
                end
            end
            rfd_pkg::RD_RUN:
            begin
                if (!pend_reg && (!out_valid_reg || out_ch.ready))
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_pos_next = cnt_reg;
                    cnt_next      = cnt_reg + 1'b1;
                    if (cnt_reg == rfd_pkg::POS_LAST)
                    begin
                        state_next = rfd_pkg::RD_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rfd_pkg::RD_IDLE;
            end
        endcase
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.frame_byte    = out_byte_reg;
    assign out_ch.byte_position = out_pos_reg;
    assign out_ch.last          = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/radar_frame_deframer_top.sv =====
// Radar frame deframer: finds the AA FF 03 00 header, gathers a fixed-length frame of
// FRAME_BYTES bytes into a RAM, checks the 55 CC tail and forwards good frames when the link
// is up. One received byte is taken per cycle while no readout runs. When a good frame ends,
// the input is held off while the frame is read back through the single read port of the
// store; each byte is read only after the one before it has been loaded into the output
// register. The last byte may still wait in the output register while new bytes come in.
// call_active drops the byte and restarts the header hunt. The store needs no clearing after reset.
// Depends on rfd_pkg, rfd_in_if, rfd_out_if, rfd_ram, rfd_parser and rfd_reader.
`default_nettype none

module radar_frame_deframer_top (
    input  wire logic clk,
    input  wire logic rst_n,
    rfd_in_if.sink    in_ch,
    rfd_out_if.source out_ch
);

    rfd_pkg::wr_req_t             wr_req;
    logic                         start;
    logic                         busy;
    logic                         accept;
    logic                         rd_en;
    logic [rfd_pkg::ADDR_W-1:0]   rd_addr;
    logic [7:0]                   rd_data;

    assign in_ch.ready = !busy;
    assign accept      = in_ch.valid && !busy;

    rfd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (in_ch.data_byte),
        .call_active (in_ch.call_active),
        .link_up     (in_ch.link_up),
        .wr_req      (wr_req),
        .start       (start)
    );

    rfd_ram #(
        .WIDTH (8),
        .DEPTH (rfd_pkg::FRAME_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_req.en),
        .wr_addr (wr_req.addr),
        .wr_data (wr_req.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rfd_reader u_reader (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for radar_frame_deframer_top: header hunt, frame gathering, tail check
// and frame forwarding, checked byte by byte against a predictor of the parser.
// Depends on rfd_pkg, rfd_in_if, rfd_out_if and the deframer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfd_pkg::*;

    localparam logic [POS_W-1:0] HUNT_POS = '0;
    localparam int RANDOM_ITEMS = 360;
    localparam int PHASE_ITEMS  = 90;

    typedef struct {
        logic [7:0]       frame_byte;
        logic [POS_W-1:0] byte_position;
        logic             last;
    } frame_beat_t;

    typedef enum int {
        SEQ_GOOD,
        SEQ_LINK_DOWN,
        SEQ_BAD_TAIL,
        SEQ_CALL_CUT,
        SEQ_NOISE,
        SEQ_BROKEN_HDR
    } seq_kind_t;

    class frame_tracker;
        logic [POS_W-1:0] parse_pos;
        logic [7:0]       frame_buf [FRAME_BYTES];
        frame_beat_t      pending_beats [$];
        int               errors;

        function new();
            parse_pos = HUNT_POS;
            errors    = 0;
        endfunction

        function void note_byte(logic [7:0] b, logic call, logic link);
            frame_beat_t beat;
            if (call)
            begin
                parse_pos = HUNT_POS;
            end
            else
            begin
                case (parse_pos)
                    HUNT_POS:
                    begin
                        if (b == HDR0)
                        begin
                            frame_buf[0] = b;
                            parse_pos    = POS_HDR1;
                        end
                    end
                    POS_HDR1:
                    begin
                        if (b == HDR1)
                        begin
                            frame_buf[1] = b;
                            parse_pos    = POS_HDR2;
                        end
                        else
                        begin
                            parse_pos = (b == HDR0) ? POS_HDR1 : HUNT_POS;
                        end
                    end
                    POS_HDR2:
                    begin
                        if (b == HDR2)
                        begin
                            frame_buf[2] = b;
                            parse_pos    = POS_HDR3;
                        end
                        else
                        begin
                            parse_pos = HUNT_POS;
                        end
                    end
                    POS_HDR3:
                    begin
                        if (b == HDR3)
                        begin
                            frame_buf[3] = b;
                            parse_pos    = POS_BODY;
                        end
                        else
                        begin
                            parse_pos = HUNT_POS;
                        end
                    end
                    default:
                    begin
                        frame_buf[parse_pos] = b;
                        if (parse_pos == POS_LAST)
                        begin
                            parse_pos = HUNT_POS;
                            if (frame_buf[POS_TAIL0] == TAIL0 && frame_buf[POS_LAST] == TAIL1
                                && link)
                            begin
                                for (int k = 0; k < FRAME_BYTES; k++)
                                begin
                                    beat.frame_byte    = frame_buf[k];
                                    beat.byte_position = POS_W'(k);
                                    beat.last          = (k == FRAME_BYTES - 1);
                                    pending_beats.push_back(beat);
                                end
                            end
                        end
                        else
                        begin
                            parse_pos = parse_pos + 1'b1;
                        end
                    end
                endcase
            end
        endfunction

        function void check_beat(logic [7:0] b, logic [POS_W-1:0] pos, logic lst);
            frame_beat_t want;
            if (pending_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction: byte %h position %0d last %b",
                         $time, b, pos, lst);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (b !== want.frame_byte)
                begin
                    errors++;
                    $display("%0t: frame_byte expected %h actual %h", $time, want.frame_byte, b);
                end
                if (pos !== want.byte_position)
                begin
                    errors++;
                    $display("%0t: byte_position expected %0d actual %0d",
                             $time, want.byte_position, pos);
                end
                if (lst !== want.last)
                begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $time, want.last, lst);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   sent_count;
    frame_tracker tracker;

    rfd_in_if  in_ch ();
    rfd_out_if out_ch ();

    radar_frame_deframer_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            tracker.check_beat(out_ch.frame_byte, out_ch.byte_position, out_ch.last);
        end
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_byte(logic [7:0] b, logic call, logic link);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < idle_pct);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.call_active <= call;
        in_ch.link_up     <= link;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        tracker.note_byte(b, call, link);
        sent_count++;
    endtask

    task automatic drain_frames();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_phase(int phase);
        case (phase)
            0:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct  = 64;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct  = 0;
                stall_pct = 64;
            end
            default:
            begin
                idle_pct  = 15;
                stall_pct = 15;
            end
        endcase
    endtask

    task automatic send_frame(seq_kind_t kind);
        logic [7:0] frame [FRAME_BYTES];
        int         cut;
        logic       link;
        frame[0] = HDR0;
        frame[1] = HDR1;
        frame[2] = HDR2;
        frame[3] = HDR3;
        for (int i = POS_BODY; i < POS_TAIL0; i++)
        begin
            frame[i] = ($urandom_range(0, 7) == 0) ? HDR0 : 8'($urandom_range(0, 255));
        end
        frame[POS_TAIL0] = TAIL0;
        frame[POS_LAST]  = TAIL1;
        if (kind == SEQ_BAD_TAIL)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                frame[POS_TAIL0] = TAIL0 ^ 8'($urandom_range(1, 255));
            end
            else
            begin
                frame[POS_LAST] = TAIL1 ^ 8'($urandom_range(1, 255));
            end
        end
        cut = (kind == SEQ_CALL_CUT) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
        for (int i = 0; i < FRAME_BYTES && i <= cut; i++)
        begin
            link = (i == FRAME_BYTES - 1) ? (kind != SEQ_LINK_DOWN) : 1'($urandom_range(0, 1));
            send_byte(frame[i], i == cut, link);
        end
    endtask

    task automatic send_noise();
        int         n;
        logic [7:0] b;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: b = HDR0;
                1: b = HDR1;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_broken_header();
        send_byte(HDR0, 1'b0, 1'($urandom_range(0, 1)));
        send_byte(HDR0, 1'b0, 1'($urandom_range(0, 1)));
        send_byte(HDR1, 1'b0, 1'($urandom_range(0, 1)));
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int        phase;
        int        pick;
        seq_kind_t kind;

        tracker           = new();
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.call_active = 1'b0;
        in_ch.link_up     = 1'b0;
        out_ch.ready      = 1'b0;
        sent_count        = 0;
        set_phase(0);
        repeat (5)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Hunt state ignores extreme bytes; a doubled AA stays at the first header step.
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(HDR0, 1'b0, 1'b1);
        send_byte(HDR0, 1'b0, 1'b0);
        send_byte(HDR1, 1'b0, 1'b1);
        send_byte(HDR2, 1'b0, 1'b1);
        send_byte(HDR3, 1'b0, 1'b1);
        send_byte(HDR0, 1'b1, 1'b1);
        // Mismatches at each header step send the hunt back to the start.
        send_byte(HDR0, 1'b0, 1'b0);
        send_byte(HDR2, 1'b0, 1'b1);
        send_byte(HDR0, 1'b0, 1'b1);
        send_byte(HDR1, 1'b0, 1'b0);
        send_byte(HDR3, 1'b0, 1'b1);
        send_byte(HDR0, 1'b0, 1'b1);
        send_byte(HDR1, 1'b0, 1'b1);
        send_byte(HDR2, 1'b0, 1'b0);
        send_byte(TAIL0, 1'b0, 1'b1);
        // Call activity in the middle of a header drops the byte regardless of the link.
        send_byte(HDR0, 1'b0, 1'b1);
        send_byte(HDR1, 1'b0, 1'b1);
        send_byte(HDR2, 1'b1, 1'b0);
        send_byte(HDR3, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);

        sent_count = 0;
        phase      = 0;
        while (sent_count < RANDOM_ITEMS)
        begin
            if (sent_count / PHASE_ITEMS != phase && phase < 3)
            begin
                phase = (sent_count / PHASE_ITEMS > 3) ? 3 : sent_count / PHASE_ITEMS;
                drain_frames();
                set_phase(phase);
            end
            pick = $urandom_range(0, 99);
            if (pick < 50)
                kind = SEQ_GOOD;
            else if (pick < 60)
                kind = SEQ_LINK_DOWN;
            else if (pick < 75)
                kind = SEQ_BAD_TAIL;
            else if (pick < 85)
                kind = SEQ_CALL_CUT;
            else if (pick < 95)
                kind = SEQ_NOISE;
            else
                kind = SEQ_BROKEN_HDR;
            case (kind)
                SEQ_NOISE:      send_noise();
                SEQ_BROKEN_HDR: send_broken_header();
                default:        send_frame(kind);
            endcase
        end

        drain_frames();
        repeat (2 * FRAME_BYTES + 20)
        begin
            @(posedge clk);
        end
        if (tracker.errors == 0 && tracker.pending_beats.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== radar_frame_deframer_top.f =====
hdl/rfd_pkg.sv
hdl/rfd_in_if.sv
hdl/rfd_out_if.sv
hdl/rfd_ram.sv
hdl/rfd_parser.sv
hdl/rfd_reader.sv
hdl/radar_frame_deframer_top.sv
test/tb.sv
